/* rtl/assert_macros.svh */
// assertion macros used by the receiver top level
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CFCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define CFCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/cfcr_pkg.sv */
// shared types, codes and the crc-8 step for the framed command receiver
// no dependencies
package cfcr_pkg;

  localparam int BURST_BYTES_DEF = 128;
  localparam int NUM_REGS        = 8;
  localparam int OUT_TDATA_W     = 48;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  typedef enum logic [2:0] {
    REG_SYNC_FIRST     = 3'd0,
    REG_SYNC_SECOND    = 3'd1,
    REG_SYNC_THIRD     = 3'd2,
    REG_MAX_LEN        = 3'd3,
    REG_TYPE_CONTROL   = 3'd4,
    REG_TYPE_HEARTBEAT = 3'd5,
    REG_TYPE_ESTOP     = 3'd6,
    REG_CONTROL_LEN    = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_CTRL_APPLIED = 3'd0,
    EV_CTRL_IGNORED = 3'd1,
    EV_HEARTBEAT    = 3'd2,
    EV_ESTOP        = 3'd3,
    EV_OTHER_TYPE   = 3'd4,
    EV_CRC_ERROR    = 3'd5,
    EV_LEN_TOO_BIG  = 3'd6,
    EV_TRUNCATED    = 3'd7
  } event_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] sync_third;
    logic [7:0] max_len;
    logic [7:0] type_control;
    logic [7:0] type_heartbeat;
    logic [7:0] type_estop;
    logic [7:0] control_len;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    event_t             code;
    logic [7:0]         frame_type;
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;
    logic               estop;
  } result_t;

  // msb first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/cfcr_parser.sv */
// per-byte frame parser: sync hunt, header, payload, crc check and command state
// uses cfcr_pkg
module cfcr_parser
  import cfcr_pkg::*;
#(
  parameter int BURST_BYTES = BURST_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  cfg_t       cfg,
  output result_t    res
);

  localparam int CntW = $clog2(BURST_BYTES + 1);

  logic [23:0]        window_r, window_nxt;
  logic [1:0]         fill_r, fill_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [7:0]         kind_r, kind_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         seen_r, seen_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [31:0]        head_r, head_nxt;
  logic signed [15:0] left_r, left_nxt;
  logic signed [15:0] right_r, right_nxt;
  logic               estop_r, estop_nxt;

  logic [7:0] crc_upd;
  logic       hit;
  event_t     code;
  logic [7:0] ftype;

  assign crc_upd = crc8_step(crc_r, in_byte);

  always_comb begin
    window_nxt = window_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    crc_nxt    = crc_r;
    head_nxt   = head_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    estop_nxt  = estop_r;
    hit        = 1'b0;
    code       = EV_OTHER_TYPE;
    ftype      = kind_r;

    if (cnt_r < CntW'(BURST_BYTES)) begin
      cnt_nxt = cnt_r + 1'b1;
      unique case (phase_r)
        PH_HUNT: begin
          window_nxt = {window_r[15:0], in_byte};
          if (fill_r != 2'd3) begin
            fill_nxt = fill_r + 1'b1;
          end
          if (fill_nxt == 2'd3 &&
              window_nxt == {cfg.sync_first, cfg.sync_second, cfg.sync_third}) begin
            phase_nxt = PH_TYPE;
            crc_nxt   = CRC_INIT;
            head_nxt  = '0;
            seen_nxt  = '0;
          end
        end
        PH_TYPE: begin
          kind_nxt  = in_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt = in_byte;
          crc_nxt = crc_upd;
          if (in_byte > cfg.max_len) begin
            phase_nxt = PH_DONE;
            hit       = 1'b1;
            code      = EV_LEN_TOO_BIG;
          end else if (in_byte == 8'd0) begin
            phase_nxt = PH_CRC;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          if (seen_r < 8'd4) begin
            head_nxt[{seen_r[1:0], 3'b000} +: 8] = head_r[{seen_r[1:0], 3'b000} +: 8] | in_byte;
          end
          seen_nxt = seen_r + 1'b1;
          if (seen_nxt >= len_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_nxt = PH_DONE;
          hit       = 1'b1;
          // type codes may overlap: control wins, then heartbeat, then estop
          priority if (in_byte != crc_r) begin
            code = EV_CRC_ERROR;
          end else if (kind_r == cfg.type_control) begin
            if (len_r != cfg.control_len || estop_r) begin
              code = EV_CTRL_IGNORED;
            end else begin
              code      = EV_CTRL_APPLIED;
              left_nxt  = head_r[15:0];
              right_nxt = head_r[31:16];
            end
          end else if (kind_r == cfg.type_heartbeat) begin
            code = EV_HEARTBEAT;
          end else if (kind_r == cfg.type_estop) begin
            code      = EV_ESTOP;
            estop_nxt = 1'b1;
            left_nxt  = '0;
            right_nxt = '0;
          end else begin
            code = EV_OTHER_TYPE;
          end
        end
        default: begin
        end
      endcase
    end

    if (in_last) begin
      // burst ended inside a frame
      if (!hit && phase_nxt != PH_HUNT && phase_nxt != PH_DONE) begin
        hit   = 1'b1;
        code  = EV_TRUNCATED;
        ftype = (phase_nxt == PH_TYPE) ? 8'd0 : kind_nxt;
      end
      window_nxt = '0;
      fill_nxt   = '0;
      phase_nxt  = PH_HUNT;
      cnt_nxt    = '0;
      kind_nxt   = '0;
      len_nxt    = '0;
      seen_nxt   = '0;
      crc_nxt    = '0;
      head_nxt   = '0;
    end

    res.valid        = hit;
    res.code         = code;
    res.frame_type   = ftype;
    res.target_left  = left_nxt;
    res.target_right = right_nxt;
    res.estop        = estop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
      phase_r  <= PH_HUNT;
      cnt_r    <= '0;
      kind_r   <= '0;
      len_r    <= '0;
      seen_r   <= '0;
      crc_r    <= '0;
      head_r   <= '0;
      left_r   <= '0;
      right_r  <= '0;
      estop_r  <= 1'b0;
    end else if (en) begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      kind_r   <= kind_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
      crc_r    <= crc_nxt;
      head_r   <= head_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      estop_r  <= estop_nxt;
    end
  end

endmodule

/* rtl/crc8_framed_command_receiver.sv */
// top level of the framed command receiver: config registers, input and output stages
// uses cfcr_pkg, cfcr_parser and assert_macros.svh
//
// Usage:
//   in_*  : one received byte per request, in_tlast marks the last byte of a burst.
//   out_* : zero or one event per byte; event code in out_tuser, frame type,
//           both pwm targets and the estop flag in out_tdata.
//   cfg_* : register writes (index 0..7), always ready; write only while idle,
//           indexes beyond 7 are dropped.
// Path: an accepted byte sits in the input register, and the parser logic
// loads its event into the output register once that register is free;
// with out_tready high the event is then taken from the output register.
// Throughput: one byte per cycle while no event waits on a stalled output,
// with the crc-8 update and phase update in the parser done combinationally.
// Stall: when the output register holds an event that is not taken, the
// input register keeps moving as long as its byte makes no event; a byte
// that does make one waits there and in_tready drops.
// Reset: rst_n (synchronous, active low) clears the parser state, the
// targets and the latched estop, empties both stages and restores the
// register defaults. No clearing pass is needed.
module crc8_framed_command_receiver
  import cfcr_pkg::*;
#(
  parameter int BURST_BYTES = BURST_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  input  logic                   in_tlast,   // burst_end
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] frame_type, [23:8] target_left, [39:24] target_right, [40] estop_active
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]             out_tuser,  // [2:0] event_code
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [7:0]             cfg_data
);

`include "assert_macros.svh"

  cfg_t    cfg_r;
  logic    s1_valid_r;
  logic [7:0] s1_byte_r;
  logic    s1_last_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    out_free;
  logic    s1_adv;
  logic    in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first     <= 8'd170;
      cfg_r.sync_second    <= 8'd85;
      cfg_r.sync_third     <= 8'd165;
      cfg_r.max_len        <= 8'd64;
      cfg_r.type_control   <= 8'd1;
      cfg_r.type_heartbeat <= 8'd2;
      cfg_r.type_estop     <= 8'd3;
      cfg_r.control_len    <= 8'd4;
    end else if (cfg_valid && cfg_index < 8'(NUM_REGS)) begin
      unique case (reg_idx_t'(cfg_index[2:0]))
        REG_SYNC_FIRST:     cfg_r.sync_first     <= cfg_data;
        REG_SYNC_SECOND:    cfg_r.sync_second    <= cfg_data;
        REG_SYNC_THIRD:     cfg_r.sync_third     <= cfg_data;
        REG_MAX_LEN:        cfg_r.max_len        <= cfg_data;
        REG_TYPE_CONTROL:   cfg_r.type_control   <= cfg_data;
        REG_TYPE_HEARTBEAT: cfg_r.type_heartbeat <= cfg_data;
        REG_TYPE_ESTOP:     cfg_r.type_estop     <= cfg_data;
        REG_CONTROL_LEN:    cfg_r.control_len    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cfcr_parser #(
    .BURST_BYTES (BURST_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_adv),
    .in_byte (s1_byte_r),
    .in_last (s1_last_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  // a byte that makes no event never waits on the output side
  assign s1_adv    = s1_valid_r && (!res.valid || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.code;
  assign out_tdata  = {7'd0, out_res_r.estop, out_res_r.target_right,
                       out_res_r.target_left, out_res_r.frame_type};

  `CFCR_ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> !out_tvalid,
    "output valid after reset")
  `CFCR_ASSERT(a_event_waits_when_blocked,
    (s1_valid_r && res.valid && !out_free) |-> !in_tready,
    "input taken while an event is blocked")
  `CFCR_ASSERT(a_applied_not_under_estop,
    (out_tvalid && out_tuser == EV_CTRL_APPLIED) |-> !out_tdata[40],
    "control applied under estop")
  `CFCR_ASSERT(a_estop_zeroes_targets,
    (out_tvalid && out_tuser == EV_ESTOP) |-> (out_tdata[40] && out_tdata[39:8] == 32'd0),
    "estop event with live targets")

endmodule

/* tb/tb_crc8_framed_command_receiver.sv */
// self-checking testbench for crc8_framed_command_receiver: byte bursts with random
// gaps and output stalls, events checked against a frame parser kept in this file
// depends on cfcr_pkg and the receiver rtl
module tb_crc8_framed_command_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcr_pkg::*;

  localparam int PHASE_BYTES  = 212;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_LINES    = 100;

  typedef struct packed {
    event_t             code;
    logic [7:0]         ftype;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               stop;
  } frame_event_t;

  typedef enum {ROW_BYTE, ROW_CRC, ROW_BAD_CRC} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [7:0]   data;
    logic         last;
    bit           typed;
    frame_event_t ev;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;   // [7:0] rx_byte
  logic                   in_tlast;   // burst_end
  logic                   out_tvalid;
  logic                   out_tready;
  // [7:0] frame_type, [23:8] target_left, [39:24] target_right, [40] estop_active
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;  // [2:0] event_code
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [7:0]             cfg_index;
  logic [7:0]             cfg_data;

  crc8_framed_command_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // parser state, mirrors the block
  logic [7:0]         regs_now [NUM_REGS];
  logic [23:0]        win;
  logic [1:0]         win_fill;
  phase_t             ph;
  int                 burst_cnt;
  logic [7:0]         kind;
  logic [7:0]         len_held;
  int                 seen;
  logic [7:0]         crc_acc;
  logic [31:0]        head;
  logic signed [15:0] tgt_left;
  logic signed [15:0] tgt_right;
  logic               stop_latched;

  frame_event_t due_events [$];
  stim_row_t    directed_rows [$];
  logic [7:0]   burst_plan [$];
  logic [7:0]   next_regs [NUM_REGS];
  int           bytes_parsed;
  int           fail_count;
  int           cycles;
  bit           quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_LINES) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
    return c;
  endfunction

  function automatic void clear_burst();
    win       = '0;
    win_fill  = '0;
    ph        = PH_HUNT;
    burst_cnt = 0;
    kind      = '0;
    len_held  = '0;
    seen      = 0;
    crc_acc   = CRC_INIT;
    head      = '0;
  endfunction

  function automatic frame_event_t make_event(input event_t code, input logic [7:0] ftype);
    frame_event_t e;
    e.code  = code;
    e.ftype = ftype;
    e.left  = tgt_left;
    e.right = tgt_right;
    e.stop  = stop_latched;
    return e;
  endfunction

  // one byte through the frame parser; returns 1 when the byte concludes an event
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output frame_event_t ev);
    bit made;
    made = 1'b0;
    ev   = '0;
    if (burst_cnt < BURST_BYTES_DEF) begin
      burst_cnt++;
      if (ph != PH_DONE) bytes_parsed++;
      case (ph)
        PH_HUNT: begin
          win = {win[15:0], b};
          if (win_fill != 2'd3) win_fill++;
          if (win_fill == 2'd3 && win == {regs_now[REG_SYNC_FIRST], regs_now[REG_SYNC_SECOND],
                                          regs_now[REG_SYNC_THIRD]}) begin
            ph      = PH_TYPE;
            crc_acc = CRC_INIT;
            head    = '0;
            seen    = 0;
          end
        end
        PH_TYPE: begin
          kind    = b;
          crc_acc = crc8_update(crc_acc, b);
          ph      = PH_LEN;
        end
        PH_LEN: begin
          len_held = b;
          crc_acc  = crc8_update(crc_acc, b);
          if (b > regs_now[REG_MAX_LEN]) begin
            ph   = PH_DONE;
            ev   = make_event(EV_LEN_TOO_BIG, kind);
            made = 1'b1;
          end else begin
            ph = (b == 8'h00) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_acc = crc8_update(crc_acc, b);
          if (seen < 4) head[seen*8 +: 8] = b;
          seen++;
          if (seen >= len_held) ph = PH_CRC;
        end
        PH_CRC: begin
          ph   = PH_DONE;
          made = 1'b1;
          if (b != crc_acc) begin
            ev = make_event(EV_CRC_ERROR, kind);
          end else if (kind == regs_now[REG_TYPE_CONTROL]) begin
            if (len_held != regs_now[REG_CONTROL_LEN] || stop_latched) begin
              ev = make_event(EV_CTRL_IGNORED, kind);
            end else begin
              // missing bytes of a short payload stay zero in head
              tgt_left  = head[15:0];
              tgt_right = head[31:16];
              ev = make_event(EV_CTRL_APPLIED, kind);
            end
          end else if (kind == regs_now[REG_TYPE_HEARTBEAT]) begin
            ev = make_event(EV_HEARTBEAT, kind);
          end else if (kind == regs_now[REG_TYPE_ESTOP]) begin
            stop_latched = 1'b1;
            tgt_left     = '0;
            tgt_right    = '0;
            ev = make_event(EV_ESTOP, kind);
          end else begin
            ev = make_event(EV_OTHER_TYPE, kind);
          end
        end
        default: ;
      endcase
    end
    // burst end still counts past capacity
    if (last) begin
      if (!made && ph != PH_HUNT && ph != PH_DONE) begin
        ev   = make_event(EV_TRUNCATED, (ph == PH_TYPE) ? 8'h00 : kind);
        made = 1'b1;
      end
      clear_burst();
    end
    return made;
  endfunction

  // one request on the input channel, then the parser sees the byte
  task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                           input frame_event_t fixed);
    int gap;
    frame_event_t ev;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (parse_byte(b, last, ev) || typed) due_events.push_back(typed ? fixed : ev);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx < NUM_REGS) regs_now[idx[2:0]] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold input until every event is out and the pipeline has emptied
  task automatic settle();
    in_tvalid = 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic row(input row_kind_t k, input logic [7:0] d, input logic last);
    stim_row_t r;
    r.kind  = k;
    r.data  = d;
    r.last  = last;
    r.typed = 1'b0;
    r.ev    = '0;
    directed_rows.push_back(r);
  endtask

  task automatic row_ev(input row_kind_t k, input logic [7:0] d, input logic last,
                        input event_t code, input logic [7:0] ftype,
                        input logic signed [15:0] left, input logic signed [15:0] right,
                        input logic stop);
    stim_row_t r;
    r.kind     = k;
    r.data     = d;
    r.last     = last;
    r.typed    = 1'b1;
    r.ev.code  = code;
    r.ev.ftype = ftype;
    r.ev.left  = left;
    r.ev.right = right;
    r.ev.stop  = stop;
    directed_rows.push_back(r);
  endtask

  // one burst: noise, a frame (possibly cut, oversized or corrupted), or a long run
  task automatic plan_burst(input bit allow_estop);
    int pick, lead, n, len, npay, cut, mx;
    logic [7:0] t, crc;
    logic [7:0] frame [$];
    burst_plan.delete();
    pick = $urandom_range(0, 99);
    mx   = regs_now[REG_MAX_LEN];
    if (pick < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) burst_plan.push_back(8'($urandom));
    end else begin
      // long lead can push the frame across the burst capacity
      lead = (pick < 12) ? $urandom_range(110, 125) : $urandom_range(0, 3);
      repeat (lead) burst_plan.push_back(8'($urandom));
      burst_plan.push_back(regs_now[REG_SYNC_FIRST]);
      burst_plan.push_back(regs_now[REG_SYNC_SECOND]);
      burst_plan.push_back(regs_now[REG_SYNC_THIRD]);
      n = $urandom_range(0, 9);
      if (n < 5) t = regs_now[REG_TYPE_CONTROL];
      else if (n < 7) t = regs_now[REG_TYPE_HEARTBEAT];
      else if (n == 7 && allow_estop) t = regs_now[REG_TYPE_ESTOP];
      else t = 8'($urandom);
      // the stop latches for good, so keep it for the last phase
      if (!allow_estop && t == regs_now[REG_TYPE_ESTOP] && t != regs_now[REG_TYPE_CONTROL] &&
          t != regs_now[REG_TYPE_HEARTBEAT])
        t = regs_now[REG_TYPE_CONTROL];
      if (pick < 20 && mx != 255) len = $urandom_range(mx + 1, 255);
      else if (t == regs_now[REG_TYPE_CONTROL] && $urandom_range(0, 3) != 0)
        len = regs_now[REG_CONTROL_LEN];
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(0, mx);
      else len = $urandom_range(0, (mx < 6) ? mx : 6);
      npay = (len > mx) ? $urandom_range(0, 3) : len;
      frame.push_back(t);
      frame.push_back(8'(len));
      repeat (npay) frame.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (frame[i]) crc = crc8_update(crc, frame[i]);
      if ($urandom_range(0, 9) == 0) crc ^= 8'(1 << $urandom_range(0, 7));
      frame.push_back(crc);
      cut = (pick >= 20 && pick < 30) ? $urandom_range(0, frame.size() - 1) : frame.size();
      for (int i = 0; i < cut; i++) burst_plan.push_back(frame[i]);
      if (cut == frame.size()) repeat ($urandom_range(0, 3)) burst_plan.push_back(8'($urandom));
    end
  endtask

  initial begin
    out_tready = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      int hold;
      hold = quiet ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_tready = 1'b0;
        do @(posedge clk); while (out_tvalid !== 1'b1);
        repeat (hold - 1) @(posedge clk);
        @(negedge clk);
        out_tready = 1'b1;
      end
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    frame_event_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (due_events.size() == 0) begin
        flag_mismatch($sformatf("event %0d with none pending", out_tuser));
      end else begin
        want = due_events.pop_front();
        if (out_tuser !== want.code)
          flag_mismatch($sformatf("event_code %0d, want %0d", out_tuser, want.code));
        if (out_tdata[7:0] !== want.ftype)
          flag_mismatch($sformatf("frame_type %0h, want %0h", out_tdata[7:0], want.ftype));
        if (out_tdata[23:8] !== want.left)
          flag_mismatch($sformatf("target_left %0h, want %0h", out_tdata[23:8], want.left));
        if (out_tdata[39:24] !== want.right)
          flag_mismatch($sformatf("target_right %0h, want %0h", out_tdata[39:24], want.right));
        if (out_tdata[40] !== want.stop)
          flag_mismatch($sformatf("estop_active %b, want %b", out_tdata[40], want.stop));
        if (out_tdata[OUT_TDATA_W-1:41] !== '0)
          flag_mismatch($sformatf("tdata pad bits %0h", out_tdata[OUT_TDATA_W-1:41]));
      end
    end
  end

  initial begin
    logic [7:0] b;
    int start;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    clear_burst();
    tgt_left     = '0;
    tgt_right    = '0;
    stop_latched = 1'b0;
    regs_now[REG_SYNC_FIRST]     = 8'd170;
    regs_now[REG_SYNC_SECOND]    = 8'd85;
    regs_now[REG_SYNC_THIRD]     = 8'd165;
    regs_now[REG_MAX_LEN]        = 8'd64;
    regs_now[REG_TYPE_CONTROL]   = 8'd1;
    regs_now[REG_TYPE_HEARTBEAT] = 8'd2;
    regs_now[REG_TYPE_ESTOP]     = 8'd3;
    regs_now[REG_CONTROL_LEN]    = 8'd4;
    bytes_parsed = 0;
    fail_count   = 0;
    cycles       = 0;
    quiet        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // control frame with both targets at their extremes, sync after a repeated first byte
    row(ROW_BYTE, 8'hAA, 1'b0); row(ROW_BYTE, 8'hAA, 1'b0); row(ROW_BYTE, 8'h55, 1'b0);
    row(ROW_BYTE, 8'hA5, 1'b0); row(ROW_BYTE, 8'h01, 1'b0); row(ROW_BYTE, 8'h04, 1'b0);
    row(ROW_BYTE, 8'h00, 1'b0); row(ROW_BYTE, 8'h80, 1'b0); row(ROW_BYTE, 8'hFF, 1'b0);
    row(ROW_BYTE, 8'h7F, 1'b0);
    row_ev(ROW_CRC, 8'h00, 1'b1, EV_CTRL_APPLIED, 8'h01, 16'sh8000, 16'sh7FFF, 1'b0);
    // heartbeat with empty payload
    row(ROW_BYTE, 8'hAA, 1'b0); row(ROW_BYTE, 8'h55, 1'b0); row(ROW_BYTE, 8'hA5, 1'b0);
    row(ROW_BYTE, 8'h02, 1'b0); row(ROW_BYTE, 8'h00, 1'b0);
    row_ev(ROW_CRC, 8'h00, 1'b1, EV_HEARTBEAT, 8'h02, 16'sh8000, 16'sh7FFF, 1'b0);
    // length over the limit, burst ends on the length byte
    row(ROW_BYTE, 8'hAA, 1'b0); row(ROW_BYTE, 8'h55, 1'b0); row(ROW_BYTE, 8'hA5, 1'b0);
    row(ROW_BYTE, 8'h01, 1'b0);
    row_ev(ROW_BYTE, 8'hFF, 1'b1, EV_LEN_TOO_BIG, 8'h01, 16'sh8000, 16'sh7FFF, 1'b0);
    // burst ends right after the sync, no type byte yet
    row(ROW_BYTE, 8'hAA, 1'b0); row(ROW_BYTE, 8'h55, 1'b0);
    row_ev(ROW_BYTE, 8'hA5, 1'b1, EV_TRUNCATED, 8'h00, 16'sh8000, 16'sh7FFF, 1'b0);
    // unknown type with a corrupted crc
    row(ROW_BYTE, 8'hAA, 1'b0); row(ROW_BYTE, 8'h55, 1'b0); row(ROW_BYTE, 8'hA5, 1'b0);
    row(ROW_BYTE, 8'hFF, 1'b0); row(ROW_BYTE, 8'h00, 1'b0);
    row_ev(ROW_BAD_CRC, 8'h00, 1'b1, EV_CRC_ERROR, 8'hFF, 16'sh8000, 16'sh7FFF, 1'b0);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CRC:     b = crc_acc;
        ROW_BAD_CRC: b = crc_acc ^ 8'h01;
        default:     b = directed_rows[i].data;
      endcase
      push_byte(b, directed_rows[i].last, directed_rows[i].typed, directed_rows[i].ev);
    end

    for (int stage = 1; stage <= 6; stage++) begin
      if (stage > 1) begin
        settle();
        foreach (next_regs[i]) next_regs[i] = regs_now[i];
        case (stage)
          2: begin
            foreach (next_regs[i]) next_regs[i] = 8'($urandom);
            next_regs[REG_MAX_LEN]     = 8'($urandom_range(4, 80));
            next_regs[REG_CONTROL_LEN] = 8'($urandom_range(0, 6));
          end
          3: begin
            // all-zero sync and fully overlapping type codes
            foreach (next_regs[i]) next_regs[i] = 8'h00;
            next_regs[REG_CONTROL_LEN] = 8'hFF;
            write_reg(8'hFF, 8'($urandom));
            write_reg(8'($urandom_range(NUM_REGS, 254)), 8'($urandom));
          end
          4: begin
            next_regs[REG_SYNC_FIRST]     = 8'hFF;
            next_regs[REG_SYNC_SECOND]    = 8'hFF;
            next_regs[REG_SYNC_THIRD]     = 8'hFF;
            next_regs[REG_MAX_LEN]        = 8'hFF;
            next_regs[REG_TYPE_CONTROL]   = 8'hFF;
            next_regs[REG_TYPE_HEARTBEAT] = 8'hFF;
            next_regs[REG_TYPE_ESTOP]     = 8'hFE;
            next_regs[REG_CONTROL_LEN]    = 8'd2;
          end
          5: begin
            foreach (next_regs[i]) next_regs[i] = 8'($urandom);
            next_regs[REG_MAX_LEN]     = 8'($urandom_range(8, 40));
            next_regs[REG_CONTROL_LEN] = 8'($urandom_range(0, 4));
          end
          default: begin
            next_regs[REG_SYNC_FIRST]     = 8'($urandom);
            next_regs[REG_SYNC_SECOND]    = 8'($urandom);
            next_regs[REG_SYNC_THIRD]     = 8'($urandom);
            next_regs[REG_MAX_LEN]        = 8'd64;
            next_regs[REG_TYPE_CONTROL]   = 8'd1;
            next_regs[REG_TYPE_HEARTBEAT] = 8'd2;
            next_regs[REG_TYPE_ESTOP]     = 8'd3;
            next_regs[REG_CONTROL_LEN]    = 8'd4;
          end
        endcase
        for (int i = 0; i < NUM_REGS; i++) write_reg(8'(i), next_regs[i]);
      end
      start = bytes_parsed;
      while (bytes_parsed < start + PHASE_BYTES) begin
        if ($urandom_range(0, 15) == 0) quiet = !quiet;
        plan_burst(stage == 6);
        foreach (burst_plan[i])
          push_byte(burst_plan[i], i == burst_plan.size() - 1, 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cfcr_pkg.sv
rtl/cfcr_parser.sv
rtl/crc8_framed_command_receiver.sv
tb/tb_crc8_framed_command_receiver.sv
